// File: rtl/mf3x3_pkg.sv
// Types and constants shared by the 3x3 max filter core: line width settings, request and result payloads.
// No dependencies.
`default_nettype none

package mf3x3_pkg;

	localparam int LINE_WIDTH_W = 11;
	localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST = 11'd1024;
	localparam int MIN_WIDTH = 3;

	typedef struct packed {
		logic [7:0] pixel;
		logic       frame_start;
		logic       frame_end;
	} in_req_t;

	typedef struct packed {
		logic [7:0] max_value;
		logic       last_of_frame;
	} out_res_t;

endpackage

`default_nettype wire

// File: rtl/max_filter_3x3_u8_core.sv
// 3x3 grayscale max filter (dilation) over a padded raster pixel stream.
// Depends on mf3x3_pkg.
//
// channel  dir  handshake           payload
// in       in   in_valid/in_stall   in_req  (pixel, frame_start, frame_end)
// out      out  out_valid/out_stall out_res (max_value, last_of_frame)
// cfg      in   cfg_we              cfg_data (line_width)
//
// One pixel per clock sustained while in_stall is low. Stage 0 issues the line
// memory read; stage 1 forms the column max, the window max and writes the
// column back; out_res and out_valid are registered after stage 1. A write-back
// to the column read in the same cycle is forwarded. Reset clears counters,
// column maxima and line_width (1024); the line memory is not cleared. out_stall
// backs up into in_stall only when a finished result still waits.
`default_nettype none

module max_filter_3x3_u8_core #(
	parameter int MAX_LINE_WIDTH = 1024
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire [mf3x3_pkg::LINE_WIDTH_W-1:0]  cfg_data,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  mf3x3_pkg::in_req_t                 in_req,
	output logic                               out_valid,
	input  wire                                out_stall,
	output mf3x3_pkg::out_res_t                out_res
);
	import mf3x3_pkg::*;

	localparam int AW = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
	localparam int WW = $clog2(MAX_LINE_WIDTH + 1);
	localparam int CW = (WW > LINE_WIDTH_W) ? WW : LINE_WIDTH_W;

	function automatic logic [7:0] max2(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? a : b;
	endfunction

	logic [LINE_WIDTH_W-1:0] line_width_q;
	logic [AW-1:0]           col_q;
	logic [1:0]              row_q;
	logic [7:0]              older_q, newer_q;

	logic                    valid_s1, emit_s1, end_s1, fwd_s1;
	logic [AW-1:0]           addr_s1;
	logic [7:0]              px_s1;
	logic [15:0]             rd_s1, fwd_s1_data;

	logic [15:0]             mem [MAX_LINE_WIDTH];

	logic                    out_valid_q;
	out_res_t                out_q;

	logic [CW-1:0]           lw_ext;
	logic [WW-1:0]           eff_w;
	logic [AW-1:0]           col_cur;
	logic [1:0]              row_cur, row_nxt;
	logic [WW-1:0]           col_inc;
	logic [AW-1:0]           col_nxt;
	logic                    accept, adv1;
	logic [7:0]              up_s1, mid_s1, cmax_s1, win_s1;
	logic [15:0]             wr_data;

	// effective width, clamped to [3, MAX_LINE_WIDTH]
	always_comb begin
		lw_ext = CW'(line_width_q);
		if (lw_ext < CW'(MIN_WIDTH)) begin
			eff_w = WW'(MIN_WIDTH);
		end else if (lw_ext > CW'(MAX_LINE_WIDTH)) begin
			eff_w = WW'(MAX_LINE_WIDTH);
		end else begin
			eff_w = lw_ext[WW-1:0];
		end
	end

	// column / row of the arriving pixel and of the next one
	always_comb begin
		col_cur = col_q;
		row_cur = row_q;
		if (in_req.frame_start) begin
			col_cur = '0;
			row_cur = '0;
		end else if (WW'(col_q) >= eff_w) begin
			col_cur = '0;
			row_cur = (row_q < 2'd2) ? row_q + 2'd1 : row_q;
		end
		col_inc = WW'(col_cur) + WW'(1);
		col_nxt = col_inc[AW-1:0];
		row_nxt = row_cur;
		if (col_inc >= eff_w) begin
			col_nxt = '0;
			row_nxt = (row_cur < 2'd2) ? row_cur + 2'd1 : row_cur;
		end
	end

	assign adv1     = valid_s1 && (!emit_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv1;
	assign accept   = in_valid && !in_stall;

	// stage 1: column max, window max
	assign {up_s1, mid_s1} = fwd_s1 ? fwd_s1_data : rd_s1;
	assign cmax_s1 = max2(max2(up_s1, mid_s1), px_s1);
	assign win_s1  = max2(max2(older_q, newer_q), cmax_s1);
	assign wr_data = {mid_s1, px_s1};

	// line memory: {upper, middle} per column
	always_ff @(posedge clk) begin
		if (adv1) begin
			mem[addr_s1] <= wr_data;
		end
		if (accept) begin
			rd_s1 <= mem[col_cur];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RST;
			col_q        <= '0;
			row_q        <= '0;
			valid_s1     <= 1'b0;
			fwd_s1       <= 1'b0;
			older_q      <= '0;
			newer_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				line_width_q <= cfg_data;
			end
			if (accept) begin
				col_q  <= col_nxt;
				row_q  <= row_nxt;
				fwd_s1 <= adv1 && (addr_s1 == col_cur);
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv1) begin
				valid_s1 <= 1'b0;
			end
			if (adv1) begin
				older_q <= newer_q;
				newer_q <= cmax_s1;
			end
			if (adv1 && emit_s1) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1     <= col_cur;
			px_s1       <= in_req.pixel;
			emit_s1     <= (row_cur >= 2'd2) && (col_cur >= AW'(2));
			end_s1      <= in_req.frame_end;
			fwd_s1_data <= wr_data;
		end
		if (adv1 && emit_s1) begin
			out_q.max_value     <= win_s1;
			out_q.last_of_frame <= end_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

`default_nettype wire

// File: verif/tb_max_filter_3x3_u8_core.sv
// Self-checking testbench for max_filter_3x3_u8_core: random padded frames at many
// line widths, random sender gaps and receiver stalls, scoreboard with window-max predictor.
// Depends on mf3x3_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_max_filter_3x3_u8_core;
	import mf3x3_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 6;

	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;
	typedef enum int {FRAME_CLEAN, FRAME_BROKEN, FRAME_NOISE} frame_kind_e;

	class window_max_tracker;
		localparam int MAX_W = 1024;
		logic [7:0] upper_line [MAX_W];
		logic [7:0] middle_line [MAX_W];
		logic [7:0] col_max_old;
		logic [7:0] col_max_new;
		int col;
		int rows_done;
		logic [LINE_WIDTH_W-1:0] width;
		out_res_t maxima_due[$];
		int errors;

		function new();
			foreach (upper_line[i]) begin
				upper_line[i] = '0;
				middle_line[i] = '0;
			end
			col_max_old = '0;
			col_max_new = '0;
			col = 0;
			rows_done = 0;
			width = LINE_WIDTH_RST;
			errors = 0;
		endfunction

		function int span_of(logic [LINE_WIDTH_W-1:0] w);
			if (w < MIN_WIDTH)
				return MIN_WIDTH;
			if (w > MAX_W)
				return MAX_W;
			return int'(w);
		endfunction

		function logic [7:0] max3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
			logic [7:0] m;
			m = (a > b) ? a : b;
			return (m > c) ? m : c;
		endfunction

		function int pending();
			return maxima_due.size();
		endfunction

		// accepted pixel request: advance window state, queue a result when one is due
		function void take_pixel(in_req_t r);
			out_res_t res;
			logic [7:0] cm;
			int w;
			w = span_of(width);
			if (r.frame_start) begin
				col = 0;
				rows_done = 0;
			end
			if (col >= w) begin
				col = 0;
				if (rows_done < 2)
					rows_done++;
			end
			cm = max3(upper_line[col], middle_line[col], r.pixel);
			if (rows_done >= 2 && col >= 2) begin
				res.max_value = max3(col_max_old, col_max_new, cm);
				res.last_of_frame = r.frame_end;
				maxima_due.push_back(res);
			end
			col_max_old = col_max_new;
			col_max_new = cm;
			upper_line[col] = middle_line[col];
			middle_line[col] = r.pixel;
			col++;
			if (col >= w) begin
				col = 0;
				if (rows_done < 2)
					rows_done++;
			end
		endfunction

		task report(string what);
			errors++;
			if (errors <= 40)
				$display("ERROR @%0t: %s", $time, what);
		endtask

		task match_result(out_res_t got);
			out_res_t want;
			if (maxima_due.size() == 0) begin
				report($sformatf("unexpected result max_value=%0d last=%0b",
					got.max_value, got.last_of_frame));
			end else begin
				want = maxima_due.pop_front();
				if (got.max_value !== want.max_value)
					report($sformatf("max_value got %0d expected %0d",
						got.max_value, want.max_value));
				if (got.last_of_frame !== want.last_of_frame)
					report($sformatf("last_of_frame got %0b expected %0b",
						got.last_of_frame, want.last_of_frame));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [LINE_WIDTH_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	in_req_t in_req;
	logic out_valid;
	logic out_stall;
	out_res_t out_res;

	window_max_tracker tracker;
	int cycles;
	int burst_left;
	int sent_items;
	bit need_start;

	max_filter_3x3_u8_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_req(in_req),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_res(out_res)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_req(logic [7:0] px, logic st, logic en);
		in_req_t r;
		logic stalled;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		if (need_start) begin
			st = 1'b1;
			need_start = 1'b0;
		end
		r.pixel = px;
		r.frame_start = st;
		r.frame_end = en;
		in_valid <= 1'b1;
		in_req <= r;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		tracker.take_pixel(r);
		sent_items++;
		burst_left--;
	endtask

	// write line_width once the pipeline has drained
	task automatic set_width(logic [LINE_WIDTH_W-1:0] w);
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= w;
		@(posedge clk);
		cfg_we <= 1'b0;
		// a wider line must restart the frame so no stale column is read
		if (tracker.span_of(w) > tracker.span_of(tracker.width))
			need_start = 1'b1;
		tracker.width = w;
	endtask

	task automatic send_frame(int w, int rows, frame_kind_e kind);
		int n;
		int cut;
		int end_at;
		n = w * rows;
		cut = n;
		end_at = n - 1;
		if (kind == FRAME_BROKEN) begin
			cut = $urandom_range(1, n - 1);
			end_at = $urandom_range(0, n - 1);
		end
		for (int i = 0; i < cut; i++)
			send_req(8'($urandom_range(0, 255)), i == 0, i == end_at);
	endtask

	task automatic run_phase(logic [LINE_WIDTH_W-1:0] w, int budget);
		int first;
		int pick;
		int span;
		set_width(w);
		span = tracker.span_of(w);
		first = sent_items;
		while (sent_items - first < budget) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				send_frame(span, $urandom_range(3, 6), FRAME_CLEAN);
			end else if (pick < 9) begin
				send_frame(span, $urandom_range(2, 5), FRAME_BROKEN);
			end else begin
				repeat ($urandom_range(1, 10))
					send_req(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0,
						$urandom_range(0, 7) == 0);
			end
		end
	endtask

	// receiver: sample before the edge, accept at the edge, then pick the next stall
	initial begin
		stall_mode_e mode;
		int mode_left;
		int tick;
		logic v;
		logic s;
		out_res_t d;
		out_stall <= 1'b0;
		mode = STALL_NONE;
		mode_left = 0;
		tick = 0;
		forever begin
			@(negedge clk);
			v = out_valid;
			s = out_stall;
			d = out_res;
			@(posedge clk);
			if (v === 1'b1 && s === 1'b0)
				tracker.match_result(d);
			if (mode_left == 0) begin
				mode = stall_mode_e'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			tick++;
			case (mode)
				STALL_NONE: out_stall <= 1'b0;
				STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
				STALL_PERIODIC: out_stall <= ((tick % 7) < 3);
				default: out_stall <= ($urandom_range(0, 9) < 8);
			endcase
		end
	end

	initial begin
		logic [7:0] seed_px [12];
		int w;
		tracker = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		in_req <= '0;
		burst_left = 0;
		sent_items = 0;
		need_start = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero width acts as three: four rows, extremes of the pixel range
		seed_px = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h00, 8'h7F,
			8'h00, 8'h00, 8'h00, 8'hFE, 8'h00, 8'h00};
		set_width('0);
		for (int i = 0; i < 12; i++)
			send_req(seed_px[i], i == 0, i == 11);
		// both marks together restart with no result
		send_req(8'hFF, 1'b1, 1'b1);
		// frame_end where no result is due
		send_req(8'h55, 1'b0, 1'b0);
		send_req(8'hAA, 1'b0, 1'b1);
		for (int i = 0; i < 6; i++)
			send_req((i % 2) ? 8'hFF : 8'h00, 1'b0, i == 5);

		for (int p = 0; p < 8; p++) begin
			if (p == 0)
				w = 1;
			else if (p == 1)
				w = 2;
			else if ($urandom_range(0, 9) < 6)
				w = $urandom_range(3, 10);
			else if ($urandom_range(0, 3) != 0)
				w = $urandom_range(11, 24);
			else
				w = $urandom_range(0, 2);
			run_phase(LINE_WIDTH_W'(w), 40);
			if (p == 4) begin
				// widest line: register above the maximum, then the maximum itself
				set_width('1);
				for (int i = 0; i < 30; i++)
					send_req(8'($urandom_range(0, 255)), i == 0, 1'b0);
				set_width(11'd1024);
				for (int i = 0; i < 10; i++)
					send_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
				// shrink mid-line without a restart: the column wraps
				set_width(11'd5);
				for (int i = 0; i < 12; i++)
					send_req(8'($urandom_range(0, 255)), 1'b0, i == 11);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES * 4) @(posedge clk);
		if (tracker.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
